FILE: design/xor_checksum_frame_deframer_macros.svh
// Assertion helpers for the deframer back end.
// Both expect clk and arst_n in scope.
`ifndef XOR_CHECKSUM_FRAME_DEFRAMER_MACROS_SVH
`define XOR_CHECKSUM_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication.
`define XCFD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define XCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/xcfd_pkg.sv
package xcfd_pkg;

	localparam int WINDOW_DEPTH  = 64;
	localparam int WIN_AW        = $clog2(WINDOW_DEPTH);
	localparam int CNT_W         = WIN_AW + 1;
	localparam int FRAME_LEN_CAP = 36;
	localparam int LEN_W         = 6;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = CFG_IDX_W'(1);

	localparam logic [LEN_W-1:0] MIN_LEN_RESET = LEN_W'(3);
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(36);

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} xcfd_beat_t;

	// Circular window index: base plus an offset of at most the depth.
	function automatic logic [WIN_AW-1:0] win_wrap(input logic [WIN_AW-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = {1'b0, CNT_W'(base)} + {1'b0, off};
		if (s >= (CNT_W+1)'(WINDOW_DEPTH))
			s = s - (CNT_W+1)'(WINDOW_DEPTH);
		return s[WIN_AW-1:0];
	endfunction

	function automatic logic source_ok(input logic [7:0] s);
		return s inside {8'h50, 8'h68, 8'h3F, 8'h3B, 8'hED, 8'h7F, 8'h80,
			8'hF0, 8'h18, 8'h6A, 8'hC8, 8'hB0, 8'hE8, 8'hD0};
	endfunction

endpackage

FILE: design/xcfd_front.sv
module xcfd_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              rx_byte,
	output xcfd_pkg::xcfd_beat_t    q_beat,
	input  logic                    q_ready
);
	import xcfd_pkg::*;

	logic [7:0]          slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   fill_q;
	logic                push;
	logic                pop;

	assign in_ready    = (fill_q < (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign push        = in_valid && in_ready;
	assign q_beat.valid = (fill_q != '0);
	assign q_beat.data  = slot_q[rd_ptr_q];
	assign pop         = q_beat.valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			if (push && !pop)
				fill_q <= fill_q + (QUEUE_AW+1)'(1);
			else if (pop && !push)
				fill_q <= fill_q - (QUEUE_AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= rx_byte;
	end

endmodule

FILE: design/xcfd_back.sv
module xcfd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  xcfd_pkg::xcfd_beat_t       q_beat,
	output logic                       q_ready,
	input  logic [xcfd_pkg::LEN_W-1:0] min_len,
	input  logic [xcfd_pkg::LEN_W-1:0] max_len,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 frame_byte,
	output logic                       first_of_frame,
	output logic                       last_of_frame
);
	import xcfd_pkg::*;
	`include "xor_checksum_frame_deframer_macros.svh"

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SEARCH  = 6'b000010,
		ST_LEN     = 6'b000100,
		ST_SUM     = 6'b001000,
		ST_EMIT_RD = 6'b010000,
		ST_EMIT_WR = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [WIN_AW-1:0] head_q, head_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [LEN_W-1:0]  cnt_q, cnt_d;
	logic              out_valid_q, out_valid_d;

	logic [LEN_W-1:0]  len_q;
	logic [7:0]        sum_q;
	logic [7:0]        src_q;
	logic [7:0]        frame_byte_q;
	logic              first_q;
	logic              last_q;

	logic [7:0]        win_mem [WINDOW_DEPTH];
	logic [7:0]        rd_data_q;
	logic              rd_en;
	logic [CNT_W-1:0]  rd_off;
	logic [WIN_AW-1:0] rd_addr;
	logic              wr_en;
	logic [WIN_AW-1:0] wr_addr;

	logic              drop_en;
	logic [CNT_W-1:0]  drop_n;
	logic              len_ld;
	logic              sum_acc;
	logic              src_ld;
	logic              out_ld;
	logic              len_bad;
	logic [CNT_W-1:0]  need;
	logic [LEN_W-1:0]  len_end;

	assign len_bad = (rd_data_q < {2'b00, min_len}) || (rd_data_q > {2'b00, max_len})
		|| (rd_data_q > 8'(FRAME_LEN_CAP));
	assign need    = CNT_W'(rd_data_q[LEN_W-1:0]) + CNT_W'(2);
	assign len_end = len_q + LEN_W'(2);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		count_d     = count_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q && !out_ready;
		drop_en     = 1'b0;
		drop_n      = '0;
		wr_en       = 1'b0;
		rd_en       = 1'b0;
		rd_off      = '0;
		len_ld      = 1'b0;
		sum_acc     = 1'b0;
		src_ld      = 1'b0;
		out_ld      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_beat.valid) begin
					// full window: drop the new beat, search anyway
					if (count_q < CNT_W'(WINDOW_DEPTH)) begin
						wr_en   = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (count_q >= CNT_W'(2)) begin
					rd_en   = 1'b1;
					rd_off  = CNT_W'(1);
					state_d = ST_LEN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_LEN: begin
				if (len_bad) begin
					drop_en = 1'b1;
					drop_n  = CNT_W'(1);
					state_d = ST_SEARCH;
				end else if (count_q < need) begin
					state_d = ST_IDLE;
				end else begin
					len_ld  = 1'b1;
					cnt_d   = '0;
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (cnt_q == len_end) begin
					// rd_data_q holds the checksum byte
					if (rd_data_q != sum_q) begin
						drop_en = 1'b1;
						drop_n  = CNT_W'(1);
						state_d = ST_SEARCH;
					end else if (!source_ok(src_q)) begin
						drop_en = 1'b1;
						drop_n  = CNT_W'(len_end);
						state_d = ST_SEARCH;
					end else begin
						cnt_d   = '0;
						state_d = ST_EMIT_RD;
					end
				end else begin
					// issue read of byte cnt, fold in byte cnt-1
					rd_en   = 1'b1;
					rd_off  = CNT_W'(cnt_q);
					sum_acc = (cnt_q != '0);
					src_ld  = (cnt_q == LEN_W'(1));
					cnt_d   = cnt_q + LEN_W'(1);
				end
			end
			ST_EMIT_RD: begin
				rd_en   = 1'b1;
				rd_off  = CNT_W'(cnt_q);
				state_d = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (!out_valid_q || out_ready) begin
					out_ld      = 1'b1;
					out_valid_d = 1'b1;
					if (cnt_q == len_q + LEN_W'(1)) begin
						drop_en = 1'b1;
						drop_n  = CNT_W'(len_end);
						state_d = ST_IDLE;
					end else begin
						cnt_d   = cnt_q + LEN_W'(1);
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (drop_en) begin
			head_d  = win_wrap(head_q, drop_n);
			count_d = count_q - drop_n;
		end
	end

	assign q_ready = (state_q == ST_IDLE);
	assign rd_addr = win_wrap(head_q, rd_off);
	assign wr_addr = win_wrap(head_q, count_q);

	always_ff @(posedge clk) begin
		if (wr_en)
			win_mem[wr_addr] <= q_beat.data;
		if (rd_en)
			rd_data_q <= win_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			count_q     <= count_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (len_ld) begin
			len_q <= rd_data_q[LEN_W-1:0];
			sum_q <= '0;
		end else if (sum_acc) begin
			sum_q <= sum_q ^ rd_data_q;
		end
		if (src_ld)
			src_q <= rd_data_q;
		if (out_ld) begin
			frame_byte_q <= rd_data_q;
			first_q      <= (cnt_q == '0);
			last_q       <= (cnt_q == len_q + LEN_W'(1));
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_byte     = frame_byte_q;
	assign first_of_frame = first_q;
	assign last_of_frame  = last_q;

	`XCFD_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(WINDOW_DEPTH), "window count above depth")
	`XCFD_ASSERT_IMPL(a_sum_len, state_q == ST_SUM, len_q <= LEN_W'(FRAME_LEN_CAP) && count_q >= CNT_W'(len_end), "checksum pass on a frame not held")
	`XCFD_ASSERT_NEXT(a_out_source, !out_valid_q && state_q != ST_EMIT_WR, !out_valid_q, "result beat outside emission")

endmodule

FILE: design/xor_checksum_frame_deframer.sv
// Length-prefixed XOR checksum deframer.
// in_valid/in_ready/rx_byte: one received bus byte per beat. A four-beat input
// queue takes bytes while the search engine is busy.
// out_valid/out_ready: one frame byte per beat, first_of_frame on the source
// byte, last_of_frame on the checksum byte.
// cfg_valid/cfg_ready/cfg_index/cfg_data: register 0 is the minimum length,
// register 1 the maximum; other indexes are ignored. cfg_ready is always high.
// Each byte is stored and the length byte probed (no probe while fewer than
// two bytes are held), then a checksum pass runs once a whole frame is
// buffered; a bad length or checksum drops one byte and the probe repeats on
// the next one, an unknown source drops the frame. An accepted frame is read
// out a byte at a time over the single read port of the 64-byte window memory.
// Reset empties the window and the input queue and loads lengths 3 and 36.
// A stalled receiver holds the output register; the engine waits, the input
// queue fills, then in_ready drops.
module xor_checksum_frame_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     frame_byte,
	output logic                           first_of_frame,
	output logic                           last_of_frame,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [xcfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [xcfd_pkg::LEN_W-1:0]     cfg_data
);
	import xcfd_pkg::*;

	xcfd_beat_t       q_beat;
	logic             q_ready;
	logic [LEN_W-1:0] min_len_q;
	logic [LEN_W-1:0] max_len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RESET;
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MIN_LEN: min_len_q <= cfg_data;
				REG_MAX_LEN: max_len_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	xcfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.q_beat   (q_beat),
		.q_ready  (q_ready)
	);

	xcfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_beat         (q_beat),
		.q_ready        (q_ready),
		.min_len        (min_len_q),
		.max_len        (max_len_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.frame_byte     (frame_byte),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame)
	);

endmodule

FILE: sim/tb_xor_checksum_frame_deframer.sv
module tb_xor_checksum_frame_deframer;
	import xcfd_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int QUIET_CYCLES = 4000;
	localparam int LONG_HOLD    = 600;
	localparam int IDLE_PCT     = 10;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

	localparam logic [7:0] KNOWN_SOURCES [14] = '{
		8'h50, 8'h68, 8'h3F, 8'h3B, 8'hED, 8'h7F, 8'h80,
		8'hF0, 8'h18, 8'h6A, 8'hC8, 8'hB0, 8'hE8, 8'hD0
	};

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} frame_beat_t;

	class frame_scoreboard;
		logic [7:0]       store [WINDOW_DEPTH];
		int               head;
		int               count;
		logic [LEN_W-1:0] min_len;
		logic [LEN_W-1:0] max_len;
		frame_beat_t      expected [$];
		int               fails;

		function new();
			head = 0;
			count = 0;
			min_len = MIN_LEN_RESET;
			max_len = MAX_LEN_RESET;
			fails = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
			if (idx == REG_MIN_LEN)
				min_len = val;
			else if (idx == REG_MAX_LEN)
				max_len = val;
		endfunction

		function logic [7:0] peek(int off);
			return store[(head + off) % WINDOW_DEPTH];
		endfunction

		function void drop(int n);
			if (n > count)
				n = count;
			head = (head + n) % WINDOW_DEPTH;
			count -= n;
		endfunction

		function bit known_source(logic [7:0] s);
			foreach (KNOWN_SOURCES[i])
				if (KNOWN_SOURCES[i] == s)
					return 1'b1;
			return 1'b0;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// Push the byte, then hunt for one frame; stop after the first one emitted.
		function void note_rx_byte(logic [7:0] b);
			int len;
			logic [7:0] sum;
			frame_beat_t beat;
			if (count < WINDOW_DEPTH) begin
				store[(head + count) % WINDOW_DEPTH] = b;
				count++;
			end
			while (count >= 2) begin
				len = peek(1);
				if (len < min_len || len > max_len || len > FRAME_LEN_CAP) begin
					drop(1);
					continue;
				end
				if (count < len + 2)
					break;
				sum = '0;
				for (int i = 0; i <= len; i++)
					sum ^= peek(i);
				if (peek(len + 1) != sum) begin
					drop(1);
					continue;
				end
				if (!known_source(peek(0))) begin
					drop(len + 2);
					continue;
				end
				for (int i = 0; i < len + 2; i++) begin
					beat.data = peek(i);
					beat.first = (i == 0);
					beat.last = (i == len + 1);
					expected.push_back(beat);
				end
				drop(len + 2);
				break;
			end
		endfunction

		function void check_beat(logic [7:0] data, logic first, logic last);
			frame_beat_t want;
			if (expected.size() == 0) begin
				$error("unexpected frame beat: frame_byte %0h", data);
				fails++;
				return;
			end
			want = expected.pop_front();
			if (data !== want.data) begin
				$error("frame_byte: expected %0h, got %0h", want.data, data);
				fails++;
			end
			if (first !== want.first) begin
				$error("first_of_frame: expected %0b, got %0b", want.first, first);
				fails++;
			end
			if (last !== want.last) begin
				$error("last_of_frame: expected %0b, got %0b", want.last, last);
				fails++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           rx_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [7:0]           frame_byte;
	logic                 first_of_frame;
	logic                 last_of_frame;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEN_W-1:0]     cfg_data = '0;

	frame_scoreboard sb = new();
	int              rx_sent = 0;
	int              cycles = 0;
	bit              no_idle = 1'b0;
	bit              hold_req = 1'b0;

	xor_checksum_frame_deframer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.frame_byte     (frame_byte),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: check each beat, then pick ready for the next cycle.
	// A requested hold starts once a result beat is waiting.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_beat(frame_byte, first_of_frame, last_of_frame);
			if (hold_req && out_valid) begin
				hold_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (!no_idle && $urandom_range(0, 99) < IDLE_PCT);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_rx_byte(b);
		rx_sent++;
	endtask

	// Source, length, length-1 data bytes, checksum. Length zero is two bytes.
	task automatic send_frame(input logic [7:0] src, input int len, input bit bad_sum,
			input int fill);
		logic [7:0] sum;
		logic [7:0] b;
		send_byte(src);
		send_byte(8'(len));
		if (len == 0)
			return;
		sum = src ^ 8'(len);
		for (int i = 2; i <= len; i++) begin
			b = (fill < 0) ? 8'($urandom) : 8'(fill);
			sum ^= b;
			send_byte(b);
		end
		if (bad_sum)
			sum ^= 8'($urandom_range(1, 255));
		send_byte(sum);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val,
			input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		if (last)
			cfg_valid <= 1'b0;
	endtask

	// Drop valid, drain expected beats, then let the engine finish any rescan.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic send_random(input int n, input int mn, input int mx);
		int start;
		int hi;
		int len;
		int kind;
		logic [7:0] src;
		start = rx_sent;
		hi = (mx > FRAME_LEN_CAP) ? FRAME_LEN_CAP : mx;
		while (rx_sent - start < n) begin
			kind = $urandom_range(0, 99);
			if (mn > hi)
				len = $urandom_range(0, 63);
			else if ($urandom_range(0, 99) < 85)
				len = mn + $urandom_range(0, (hi - mn < 5) ? hi - mn : 5);
			else
				len = $urandom_range(mn, hi);
			if ($urandom_range(0, 99) < 85)
				src = KNOWN_SOURCES[$urandom_range(0, 13)];
			else
				src = 8'($urandom);
			if (kind < 72) begin
				send_frame(src, len, 1'b0, -1);
			end else if (kind < 84) begin
				send_frame(src, len, 1'b1, -1);
			end else if (kind < 94) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
			end else begin
				// cut-off frame: header and up to len random bytes
				send_byte(src);
				send_byte(8'(len));
				repeat ($urandom_range(0, len)) send_byte(8'($urandom));
			end
		end
	endtask

	task automatic run_phase(input int mn, input int mx, input int n);
		settle();
		write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, LEN_W'($urandom), 1'b0);
		write_reg(REG_MIN_LEN, LEN_W'(mn), 1'b0);
		write_reg(REG_MAX_LEN, LEN_W'(mx), 1'b1);
		send_random(n, mn, mx);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset lengths: good frame, bad checksum, rejected source
		send_frame(8'h50, 3, 1'b0, 8'h00);
		send_frame(8'hD0, 3, 1'b1, 8'hFF);
		send_frame(8'h00, 3, 1'b0, 8'hFF);
		// false header spanning two good frames: after its checksum fails, the
		// first inner frame comes out and the second waits for the next beat
		send_byte(8'h50);
		send_byte(8'h0A);
		send_frame(8'h3B, 3, 1'b0, 8'h00);
		send_frame(8'hED, 3, 1'b0, 8'hFF);

		settle();
		hold_req = 1'b1;
		run_phase(1, 62, 50);
		settle();
		no_idle = 1'b1;
		run_phase(0, 63, 50);
		settle();
		no_idle = 1'b0;
		run_phase(36, 36, 60);
		run_phase(45, 10, 15);
		run_phase(20, 30, 30);
		run_phase(3, 36, 40);
		settle();

		if (sb.fails == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
